### rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants of the address record endpoint parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  // Record header layout (byte positions, counted from zero)
  localparam int          HEADER_BYTES   = 24;
  localparam logic [4:0]  HDR_MAGIC_END  = 5'd3;
  localparam logic [4:0]  HDR_FAMILY_END = 5'd11;
  localparam logic [4:0]  HDR_LAST       = 5'(HEADER_BYTES - 1);

  // Socket address rules
  localparam logic [31:0] FAMILY_INET      = 32'd2;
  localparam logic [31:0] FAMILY_INET6     = 32'd28;
  localparam logic [31:0] INET_ADDR_BYTES  = 32'd16;
  localparam logic [31:0] INET6_ADDR_BYTES = 32'd28;
  localparam logic [31:0] EMPTY_ADDR_LEN   = 32'd4;
  localparam logic [31:0] MIN_ADDR_LEN     = 32'd4;

  // Address bytes 0..23 are the only ones ever examined
  localparam int ADDR_KEEP = 24;
  typedef logic [ADDR_KEEP-1:0][7:0] addr_bytes_t;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND   = 2'd0;
  localparam logic [1:0] STATUS_BAD     = 2'd1;
  localparam logic [1:0] STATUS_NO_ADDR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ADDR,
    PH_NAME
  } phase_t;

  // Verdict on one socket address
  typedef struct packed {
    logic        ok;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } addr_check_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic        is_ipv6;
    logic [15:0] port_number;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
  } out_item_t;

endpackage

### rtl/aip_if.sv
// ----------------------------------------------------------------------------
// aip_if
// Valid/ready channels: byte stream in, endpoint result out.
// ----------------------------------------------------------------------------
interface aip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aip_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_ipv6;
  logic [15:0] port_number;
  logic [63:0] addr_upper;
  logic [63:0] addr_lower;

  modport source (output valid, output status, output is_ipv6, output port_number,
                  output addr_upper, output addr_lower, input ready);
  modport sink   (input valid, input status, input is_ipv6, input port_number,
                  input addr_upper, input addr_lower, output ready);
endinterface

### rtl/aip_addr_check.sv
// ----------------------------------------------------------------------------
// aip_addr_check
// Validates a socket address against the record family and extracts the
// port and address words.
// ----------------------------------------------------------------------------
module aip_addr_check (
  input  aip_pkg::addr_bytes_t addr_bytes,
  input  logic [31:0]          addr_len,
  input  logic [31:0]          family,
  output aip_pkg::addr_check_t verdict
);

  logic [31:0] lead;
  logic [31:0] fam_byte;
  logic        base_ok;

  assign lead     = {24'd0, addr_bytes[0]};
  assign fam_byte = {24'd0, addr_bytes[1]};
  assign base_ok  = (addr_len >= aip_pkg::MIN_ADDR_LEN) && (fam_byte == family) &&
                    (lead <= addr_len);

  // Judge by family and pack the address words
  always_comb begin
    verdict         = '0;
    verdict.port    = {addr_bytes[2], addr_bytes[3]};
    priority if (family == aip_pkg::FAMILY_INET) begin
      verdict.ok      = base_ok && (addr_len >= aip_pkg::INET_ADDR_BYTES) &&
                        (lead >= aip_pkg::INET_ADDR_BYTES);
      verdict.is_ipv6 = 1'b0;
      verdict.addr_hi = {addr_bytes[4], addr_bytes[5], addr_bytes[6], addr_bytes[7], 32'd0};
    end else if (family == aip_pkg::FAMILY_INET6) begin
      verdict.ok      = base_ok && (addr_len >= aip_pkg::INET6_ADDR_BYTES) &&
                        (lead >= aip_pkg::INET6_ADDR_BYTES);
      verdict.is_ipv6 = 1'b1;
      for (int i = 0; i < 8; i++) begin
        verdict.addr_hi[63-8*i -: 8] = addr_bytes[8+i];
        verdict.addr_lo[63-8*i -: 8] = addr_bytes[16+i];
      end
    end else begin
      verdict.ok = 1'b0;
    end
  end

endmodule

### rtl/aip_parse_core.sv
// ----------------------------------------------------------------------------
// aip_parse_core
// Per-byte record parser: header fields, address capture, name skip, and
// the result for the final byte of a buffer.
// ----------------------------------------------------------------------------
module aip_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_valid,
  input  logic [7:0]          step_byte,
  input  logic                step_last,
  input  logic [31:0]         record_magic,
  output logic                res_valid,
  output aip_pkg::out_item_t  res_item
);

  aip_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]     hdr_word_r, hdr_word_nxt;
  logic [31:0]     family_r, family_nxt;
  logic [31:0]     addr_len_r, addr_len_nxt;
  logic [31:0]     addr_cnt_r, addr_cnt_nxt;
  logic            found_r, found_nxt;
  logic            err_r, err_nxt;
  logic            ch_ipv6_r, ch_ipv6_nxt;
  logic [15:0]     ch_port_r, ch_port_nxt;
  logic [63:0]     ch_hi_r, ch_hi_nxt;
  logic [63:0]     ch_lo_r, ch_lo_nxt;
  logic [7:0]      store_r [aip_pkg::ADDR_KEEP];

  logic                 take;
  logic                 clear;
  logic [31:0]          shifted;
  logic [31:0]          cnt_inc;
  logic                 addr_done;
  logic                 store_wr;
  aip_pkg::addr_bytes_t merged;
  aip_pkg::addr_check_t verdict;

  assign take      = step_valid && !err_r;
  assign clear     = step_valid && step_last;
  assign shifted   = {hdr_word_r[23:0], step_byte};
  assign cnt_inc   = addr_cnt_r + 32'd1;
  assign addr_done = (phase_r == aip_pkg::PH_ADDR) && (cnt_inc == addr_len_r);
  assign store_wr  = take && (phase_r == aip_pkg::PH_ADDR) &&
                     (addr_cnt_r < 32'(aip_pkg::ADDR_KEEP));

  // Overlay the byte being written on the stored address
  always_comb begin
    for (int i = 0; i < aip_pkg::ADDR_KEEP; i++) begin
      merged[i] = (addr_cnt_r == 32'(i)) ? step_byte : store_r[i];
    end
  end

  aip_addr_check u_check (
    .addr_bytes (merged),
    .addr_len   (addr_len_r),
    .family     (family_r),
    .verdict    (verdict)
  );

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        aip_pkg::PH_HEADER: if (hdr_cnt_r == aip_pkg::HDR_LAST) phase_nxt = aip_pkg::PH_ADDR;
        aip_pkg::PH_ADDR:   if (addr_done) phase_nxt = aip_pkg::PH_NAME;
        aip_pkg::PH_NAME:   if (step_byte == 8'd0) phase_nxt = aip_pkg::PH_HEADER;
        default:            phase_nxt = phase_r;
      endcase
    end
  end

  // Header counters, address counters and the kept endpoint
  always_comb begin
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_word_nxt = hdr_word_r;
    family_nxt   = family_r;
    addr_len_nxt = addr_len_r;
    addr_cnt_nxt = addr_cnt_r;
    found_nxt    = found_r;
    err_nxt      = err_r;
    ch_ipv6_nxt  = ch_ipv6_r;
    ch_port_nxt  = ch_port_r;
    ch_hi_nxt    = ch_hi_r;
    ch_lo_nxt    = ch_lo_r;
    if (take) begin
      unique case (phase_r)
        aip_pkg::PH_HEADER: begin
          hdr_word_nxt = shifted;
          if (hdr_cnt_r == aip_pkg::HDR_MAGIC_END && shifted != record_magic) begin
            err_nxt = 1'b1;
          end else if (hdr_cnt_r == aip_pkg::HDR_FAMILY_END) begin
            family_nxt = shifted;
          end
          if (hdr_cnt_r == aip_pkg::HDR_LAST) begin
            addr_len_nxt = (shifted == 32'd0) ? aip_pkg::EMPTY_ADDR_LEN : shifted;
            addr_cnt_nxt = 32'd0;
            hdr_cnt_nxt  = 5'd0;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 5'd1;
          end
        end
        aip_pkg::PH_ADDR: begin
          addr_cnt_nxt = cnt_inc;
          if (addr_done && !found_r && verdict.ok) begin
            found_nxt   = 1'b1;
            ch_ipv6_nxt = verdict.is_ipv6;
            ch_port_nxt = verdict.port;
            ch_hi_nxt   = verdict.addr_hi;
            ch_lo_nxt   = verdict.addr_lo;
          end
        end
        aip_pkg::PH_NAME: begin
          if (step_byte == 8'd0) begin
            hdr_cnt_nxt  = 5'd0;
            hdr_word_nxt = 32'd0;
          end
        end
        default: begin
          hdr_cnt_nxt = hdr_cnt_r;
        end
      endcase
    end
  end

  // Result for the final byte, taken from the updated state
  always_comb begin
    res_valid = clear;
    res_item  = '0;
    if (err_nxt || phase_nxt != aip_pkg::PH_HEADER || hdr_cnt_nxt != 5'd0) begin
      res_item.status = aip_pkg::STATUS_BAD;
    end else if (!found_nxt) begin
      res_item.status = aip_pkg::STATUS_NO_ADDR;
    end else begin
      res_item.status      = aip_pkg::STATUS_FOUND;
      res_item.is_ipv6     = ch_ipv6_nxt;
      res_item.port_number = ch_port_nxt;
      res_item.addr_upper  = ch_hi_nxt;
      res_item.addr_lower  = ch_lo_nxt;
    end
  end

  // Advance state; drop everything after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r    <= aip_pkg::PH_HEADER;
      hdr_cnt_r  <= 5'd0;
      hdr_word_r <= 32'd0;
      family_r   <= 32'd0;
      addr_len_r <= 32'd0;
      addr_cnt_r <= 32'd0;
      found_r    <= 1'b0;
      err_r      <= 1'b0;
      ch_ipv6_r  <= 1'b0;
      ch_port_r  <= 16'd0;
      ch_hi_r    <= 64'd0;
      ch_lo_r    <= 64'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_word_r <= hdr_word_nxt;
      family_r   <= family_nxt;
      addr_len_r <= addr_len_nxt;
      addr_cnt_r <= addr_cnt_nxt;
      found_r    <= found_nxt;
      err_r      <= err_nxt;
      ch_ipv6_r  <= ch_ipv6_nxt;
      ch_port_r  <= ch_port_nxt;
      ch_hi_r    <= ch_hi_nxt;
      ch_lo_r    <= ch_lo_nxt;
    end
  end

  // Capture address bytes
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[addr_cnt_r[4:0]] <= step_byte;
    end
  end

endmodule

### rtl/addrinfo_record_endpoint_parser.sv
// ----------------------------------------------------------------------------
// addrinfo_record_endpoint_parser
// Top level: input register, record parser, result register.
// ----------------------------------------------------------------------------
// The block takes one byte of a record buffer per cycle, back to back, and
// produces one result per buffer, for the byte flagged as last. A byte is
// parsed straight from the input register, and the result for a final byte
// is registered in the output register. Every byte is handled by one pass
// of counter, shift and compare logic, which sets the rate at one byte per
// cycle; input stalls only while the byte in the input register is a final
// byte and the output register still holds a result that has not been
// taken. The user is to write the expected magic word through the cfg port
// only while no buffer is in flight; the block itself does not enforce it.
module addrinfo_record_endpoint_parser (
  input  logic                clk,
  input  logic                rst_n,
  aip_byte_if.sink            in_ch,
  aip_result_if.source        out_ch,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  logic               in_v_r;
  logic [7:0]         in_byte_r;
  logic               in_last_r;
  logic               adv;
  logic [31:0]        magic_r;
  logic               out_v_r;
  aip_pkg::out_item_t out_item_r;
  logic               res_valid;
  aip_pkg::out_item_t res_item;

  // Move a byte into the parser unless its result has nowhere to go
  assign adv         = in_v_r && (!in_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  // Hold the magic word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= 32'd0;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  aip_parse_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (adv),
    .step_byte    (in_byte_r),
    .step_last    (in_last_r),
    .record_magic (magic_r),
    .res_valid    (res_valid),
    .res_item     (res_item)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_item_r.status;
  assign out_ch.is_ipv6     = out_item_r.is_ipv6;
  assign out_ch.port_number = out_item_r.port_number;
  assign out_ch.addr_upper  = out_item_r.addr_upper;
  assign out_ch.addr_lower  = out_item_r.addr_lower;

endmodule

### sim/addrinfo_record_endpoint_parser_test.sv
// ----------------------------------------------------------------------------
// addrinfo_record_endpoint_parser_test
// Self-checking bench for the record buffer endpoint parser. Buffers of
// records, built to reach deep into the parse, go in byte by byte. A
// behavioral parser predicts each buffer's result, and every result that
// comes out is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module addrinfo_record_endpoint_parser_test;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int ITEM_TARGET     = 1800;
  localparam int MIN_BUFFERS     = 4;
  localparam int SA_STORE        = 28;
  localparam int FILL_RANDOM     = -1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  aip_byte_if   byte_ch ();
  aip_result_if result_ch ();

  addrinfo_record_endpoint_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (byte_ch),
    .out_ch      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser model state
  logic [31:0]     magic_word;
  aip_pkg::phase_t scan_phase;
  int              hdr_idx;
  logic [31:0]     hdr_shift;
  logic [31:0]     rec_family;
  logic [31:0]     addr_len;
  logic [31:0]     addr_idx;
  logic [7:0]      addr_buf [SA_STORE];
  bit              have_endpoint;
  bit              saw_error;
  logic            ep_ipv6;
  logic [15:0]     ep_port;
  logic [63:0]     ep_hi;
  logic [63:0]     ep_lo;

  aip_pkg::out_item_t endpoint_q [$];
  logic [7:0]         pending_bytes [$];

  int fail_count    = 0;
  int results_seen  = 0;
  int bytes_sent    = 0;
  int buffers_sent  = 0;
  int cycle_count   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  bit idle_on       = 1'b1;
  bit sender_live   = 1'b0;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_parse_state();
    scan_phase    = aip_pkg::PH_HEADER;
    hdr_idx       = 0;
    hdr_shift     = '0;
    rec_family    = '0;
    addr_len      = '0;
    addr_idx      = '0;
    have_endpoint = 1'b0;
    saw_error     = 1'b0;
    ep_ipv6       = 1'b0;
    ep_port       = '0;
    ep_hi         = '0;
    ep_lo         = '0;
    foreach (addr_buf[i]) addr_buf[i] = '0;
  endfunction

  // Keep the socket address if it is the first valid one of the buffer
  function automatic void judge_sockaddr();
    logic [31:0] lead;
    lead = {24'h0, addr_buf[0]};
    if (have_endpoint || addr_len < aip_pkg::MIN_ADDR_LEN) return;
    if ({24'h0, addr_buf[1]} != rec_family || lead > addr_len) return;
    if (rec_family == aip_pkg::FAMILY_INET) begin
      if (addr_len < aip_pkg::INET_ADDR_BYTES || lead < aip_pkg::INET_ADDR_BYTES) return;
      ep_ipv6 = 1'b0;
      ep_hi   = {addr_buf[4], addr_buf[5], addr_buf[6], addr_buf[7], 32'h0};
      ep_lo   = '0;
    end else if (rec_family == aip_pkg::FAMILY_INET6) begin
      if (addr_len < aip_pkg::INET6_ADDR_BYTES || lead < aip_pkg::INET6_ADDR_BYTES) return;
      ep_ipv6 = 1'b1;
      for (int i = 0; i < 8; i++) begin
        ep_hi = {ep_hi[55:0], addr_buf[8 + i]};
        ep_lo = {ep_lo[55:0], addr_buf[16 + i]};
      end
    end else begin
      return;
    end
    ep_port       = {addr_buf[2], addr_buf[3]};
    have_endpoint = 1'b1;
  endfunction

  // Advance the model by one byte; return 1 with the result on a final byte
  function automatic bit absorb_byte(input logic [7:0] b, input logic is_final,
                                     output aip_pkg::out_item_t res);
    res = '0;
    if (!saw_error) begin
      case (scan_phase)
        aip_pkg::PH_HEADER: begin
          hdr_shift = {hdr_shift[23:0], b};
          if (hdr_idx == 3 && hdr_shift != magic_word) saw_error = 1'b1;
          else if (hdr_idx == 11) rec_family = hdr_shift;
          if (hdr_idx == aip_pkg::HEADER_BYTES - 1) begin
            addr_len   = (hdr_shift == 0) ? aip_pkg::EMPTY_ADDR_LEN : hdr_shift;
            addr_idx   = '0;
            scan_phase = aip_pkg::PH_ADDR;
            hdr_idx    = 0;
          end else begin
            hdr_idx++;
          end
        end
        aip_pkg::PH_ADDR: begin
          if (addr_idx < SA_STORE) addr_buf[addr_idx] = b;
          addr_idx++;
          if (addr_idx == addr_len) begin
            judge_sockaddr();
            scan_phase = aip_pkg::PH_NAME;
          end
        end
        default: begin
          if (b == 8'h00) begin
            scan_phase = aip_pkg::PH_HEADER;
            hdr_idx    = 0;
            hdr_shift  = '0;
          end
        end
      endcase
    end
    if (!is_final) return 1'b0;
    if (saw_error || scan_phase != aip_pkg::PH_HEADER || hdr_idx != 0) begin
      res.status = aip_pkg::STATUS_BAD;
    end else if (!have_endpoint) begin
      res.status = aip_pkg::STATUS_NO_ADDR;
    end else begin
      res.status      = aip_pkg::STATUS_FOUND;
      res.is_ipv6     = ep_ipv6;
      res.port_number = ep_port;
      res.addr_upper  = ep_hi;
      res.addr_lower  = ep_lo;
    end
    clear_parse_state();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Buffer construction
  // --------------------------------------------------------------------------
  function automatic void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) pending_bytes.push_back(w[8*i +: 8]);
  endfunction

  // Append one record: header, socket address, then a terminated name
  function automatic void add_record(input logic [31:0] magic, input logic [31:0] family,
                                     input logic [31:0] len_field, input logic [7:0] lead,
                                     input logic [7:0] sa_family, input int addr_bytes,
                                     input int name_len, input int fill);
    logic [7:0] b;
    push_word(magic);
    push_word($urandom());
    push_word(family);
    push_word($urandom());
    push_word($urandom());
    push_word(len_field);
    for (int i = 0; i < addr_bytes; i++) begin
      if (i == 0) b = lead;
      else if (i == 1) b = sa_family;
      else if (fill < 0) b = 8'($urandom());
      else b = fill[7:0];
      pending_bytes.push_back(b);
    end
    for (int i = 0; i < name_len; i++) pending_bytes.push_back(8'($urandom_range(1, 255)));
    pending_bytes.push_back(8'h00);
  endfunction

  function automatic void cut_to(input int keep);
    while (pending_bytes.size() > keep) void'(pending_bytes.pop_back());
  endfunction

  function automatic void add_random_record(input logic [31:0] magic);
    int          kind;
    int          len;
    int          name_len;
    logic [31:0] fam;
    kind     = $urandom_range(0, 9);
    name_len = $urandom_range(0, 5);
    fam      = $urandom_range(0, 1) ? aip_pkg::FAMILY_INET : aip_pkg::FAMILY_INET6;
    case (kind)
      0, 1, 2: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 32) : 16;
        add_record(magic, aip_pkg::FAMILY_INET, len, 8'($urandom_range(16, len)),
                   8'(aip_pkg::FAMILY_INET), len, name_len, FILL_RANDOM);
      end
      3, 4, 5: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 40) : 28;
        add_record(magic, aip_pkg::FAMILY_INET6, len, 8'($urandom_range(28, len)),
                   8'(aip_pkg::FAMILY_INET6), len, name_len, FILL_RANDOM);
      end
      // Lead byte anywhere
      6: begin
        len = $urandom_range(4, 40);
        add_record(magic, fam, len, 8'($urandom()), 8'(fam), len, name_len, FILL_RANDOM);
      end
      // Address family byte anywhere
      7: begin
        len = (fam == aip_pkg::FAMILY_INET) ? 16 : 28;
        add_record(magic, fam, len, 8'(len), 8'($urandom()), len, name_len, FILL_RANDOM);
      end
      // Short or empty address
      8: begin
        len = $urandom_range(0, 15);
        add_record(magic, fam, len, 8'($urandom_range(0, 15)), 8'(fam),
                   (len == 0) ? 4 : len, name_len, FILL_RANDOM);
      end
      default: begin
        fam = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 40);
        len = $urandom_range(0, 40);
        add_record(magic, fam, len, 8'($urandom()), 8'(fam), (len == 0) ? 4 : len,
                   name_len, FILL_RANDOM);
      end
    endcase
  endfunction

  // Mostly well-formed record runs, some noise, some bad magic, some cut short
  function automatic void build_random_buffer();
    int r;
    int nrec;
    int bad_at;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 30)) pending_bytes.push_back(8'($urandom()));
      return;
    end
    nrec   = $urandom_range(1, 3);
    bad_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, nrec - 1) : -1;
    for (int i = 0; i < nrec; i++)
      add_random_record((i == bad_at) ? magic_word ^ (32'h1 << $urandom_range(0, 31))
                                      : magic_word);
    if ($urandom_range(0, 99) < 12) cut_to($urandom_range(1, pending_bytes.size() - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_final);
    aip_pkg::out_item_t res;
    int                 gap;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= is_final;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_sent++;
    if (absorb_byte(b, is_final, res)) endpoint_q.push_back(res);
    gap = pick_gap();
    sender_live = (gap == 0);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_buffer();
    int n;
    n = pending_bytes.size();
    for (int i = 0; i < n; i++) send_byte(pending_bytes[i], i == n - 1);
    pending_bytes.delete();
    buffers_sent++;
  endtask

  // Drop valid if the last request left it high
  task automatic park_sender();
    if (sender_live) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
      sender_live = 1'b0;
    end
  endtask

  task automatic wait_drained();
    park_sender();
    while (endpoint_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    magic_word  = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------
  // Hold ready low for a requested hold-off, else stall at random
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      result_ch.ready <= (stall_left == 0);
    end
  end

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // Compare each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    aip_pkg::out_item_t want;
    if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (endpoint_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with no request pending: expected none, actual status %0d",
                 $time, result_ch.status);
      end else begin
        want = endpoint_q.pop_front();
        check_field("status", 64'(want.status), 64'(result_ch.status));
        check_field("is_ipv6", 64'(want.is_ipv6), 64'(result_ch.is_ipv6));
        check_field("port_number", 64'(want.port_number), 64'(result_ch.port_number));
        check_field("addr_upper", want.addr_upper, result_ch.addr_upper);
        check_field("addr_lower", want.addr_lower, result_ch.addr_lower);
        results_seen++;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, endpoint_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Magic after reset is zero: a zero-magic record parses, any other fails
  task automatic test_reset_magic();
    add_record(32'h0, aip_pkg::FAMILY_INET, 32'd16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    send_buffer();
    add_record(32'h8000_0000, aip_pkg::FAMILY_INET, 32'd16, 8'd16, 8'(aip_pkg::FAMILY_INET),
               16, 2, FILL_RANDOM);
    send_buffer();
  endtask

  task automatic test_directed_records();
    wait_drained();
    write_magic(32'hFFFF_FFFF);
    // All-ones IPv4 endpoint with an empty name
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 0,
               255);
    send_buffer();
    // All-zero IPv6 endpoint of minimum length
    add_record(magic_word, aip_pkg::FAMILY_INET6, 28, 8'd28, 8'(aip_pkg::FAMILY_INET6), 28, 1,
               0);
    send_buffer();
    // Long IPv6 address counted past the store
    add_record(magic_word, aip_pkg::FAMILY_INET6, 255, 8'd255, 8'(aip_pkg::FAMILY_INET6), 255,
               3, FILL_RANDOM);
    send_buffer();
    // Lead byte beyond the length
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd17, 8'(aip_pkg::FAMILY_INET), 16, 1,
               FILL_RANDOM);
    send_buffer();
    // Lead byte below the IPv4 minimum
    add_record(magic_word, aip_pkg::FAMILY_INET, 20, 8'd15, 8'(aip_pkg::FAMILY_INET), 20, 1,
               FILL_RANDOM);
    send_buffer();
    // IPv6 record too short
    add_record(magic_word, aip_pkg::FAMILY_INET6, 16, 8'd16, 8'(aip_pkg::FAMILY_INET6), 16, 1,
               FILL_RANDOM);
    send_buffer();
    // Zero length counts as four bytes
    add_record(magic_word, aip_pkg::FAMILY_INET, 0, 8'd4, 8'(aip_pkg::FAMILY_INET), 4, 1,
               FILL_RANDOM);
    send_buffer();
    // Length under four
    add_record(magic_word, aip_pkg::FAMILY_INET, 3, 8'd3, 8'(aip_pkg::FAMILY_INET), 3, 1,
               FILL_RANDOM);
    send_buffer();
    // Address family byte disagrees with the record
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET6), 16, 1,
               FILL_RANDOM);
    send_buffer();
    // Unknown family, and a family word with upper bits set
    add_record(magic_word, 32'd10, 16, 8'd16, 8'd10, 16, 1, FILL_RANDOM);
    send_buffer();
    add_record(magic_word, 32'h0000_0102, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 1,
               FILL_RANDOM);
    send_buffer();
    // First valid endpoint is kept
    add_record(magic_word, aip_pkg::FAMILY_INET6, 28, 8'd28, 8'(aip_pkg::FAMILY_INET6), 28, 2,
               FILL_RANDOM);
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    send_buffer();
    // Invalid record then a valid one
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd17, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    send_buffer();
    // Bad magic after an endpoint: the error wins
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    add_record(32'h0, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    send_buffer();
    // Cut inside the header, inside the address, before the name terminator
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    cut_to(10);
    send_buffer();
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 2,
               FILL_RANDOM);
    cut_to(30);
    send_buffer();
    add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16, 3,
               FILL_RANDOM);
    cut_to(pending_bytes.size() - 1);
    send_buffer();
    // Maximum length field never completes
    add_record(magic_word, aip_pkg::FAMILY_INET, 32'hFFFF_FFFF, 8'd16,
               8'(aip_pkg::FAMILY_INET), 20, 0, FILL_RANDOM);
    send_buffer();
    // Single-byte buffers
    pending_bytes.push_back(8'h00);
    send_buffer();
    pending_bytes.push_back(8'hFF);
    send_buffer();
  endtask

  // Hold off the receiver so the block fills and stalls, then drain fully
  task automatic test_output_hold();
    wait_drained();
    idle_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0)
        add_record(magic_word, aip_pkg::FAMILY_INET, 16, 8'd16, 8'(aip_pkg::FAMILY_INET), 16,
                   0, FILL_RANDOM);
      else
        pending_bytes.push_back(8'($urandom()));
      send_buffer();
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Random buffers across several magic settings, with no-idle stretches
  task automatic test_random_buffers();
    int          n_buf;
    logic [31:0] m;
    n_buf = 0;
    while (bytes_sent < ITEM_TARGET || n_buf < MIN_BUFFERS) begin
      if (n_buf % 2 == 0) begin
        wait_drained();
        case ((n_buf / 2) % 4)
          1:       m = 32'h0;
          2:       m = 32'hFFFF_FFFF;
          default: m = $urandom();
        endcase
        write_magic(m);
      end
      idle_on = (n_buf % 3 != 2);
      build_random_buffer();
      send_buffer();
      n_buf++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    magic_word        = '0;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_magic();
    test_directed_records();
    test_output_hold();
    test_random_buffers();

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Run covered %0d buffers and %0d checked results over several magic words,",
             buffers_sent, results_seen);
    $display("with directed record cases, output hold-off and random record streams.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
